[rtl/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// Move-to-front codec package
// Shared widths, operation codes, controller states and the cell control
// bundle used by the list cells and the top level.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int SYM_W = 8;

    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic
    {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    typedef enum logic
    {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    typedef struct packed
    {
        logic  load;
        logic  start;
        logic  decode;
        sym_t  data;
        logic  update;
        logic  found;
        sym_t  pos;
        sym_t  front;
    } cell_ctrl_t;

endpackage

[rtl/move_to_front_codec.sv]
// ----------------------------------------------------------------------------
// Move-to-front codec
// Byte-wide move-to-front encoder and decoder built as a row of list cells.
// ----------------------------------------------------------------------------
// The input channel carries func, data_in and start_of_block under
// in_valid and in_stall; the output channel carries data_out under
// out_valid and out_stall. An encode transfer returns the rank of the
// symbol in the list, a decode transfer returns the symbol at the given
// rank, and in both cases the symbol then moves to the front.
// In the accept cycle every cell compares its entry, or for a decode its
// index, with the byte and registers a match flag; a start of block
// loads identity order at once. In the next cycle the match flags are
// reduced, the cells ahead of the hit shift down one place and the result
// is written to the output register. No new byte is taken until this
// compare and update pair is done.
// Reset puts the list in identity order and empties the output register.
// While the output register is full and stalled, no new transfer is taken.
// ----------------------------------------------------------------------------
module move_to_front_codec #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          func,
    input  mtf_pkg::sym_t data_in,
    input  logic          start_of_block,
    output logic          out_valid,
    input  logic          out_stall,
    output mtf_pkg::sym_t data_out
);
    import mtf_pkg::*;

    localparam int N = ALPHABET_SIZE;

    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    sym_t       data_out_reg;
    logic       decode_reg;
    logic       accept;
    logic       update;
    cell_ctrl_t ctrl;
    logic       found;
    sym_t       pos;
    sym_t       hit_sym;

    logic [N-1:0]            match;
    logic [N-1:0][SYM_W-1:0] syms;

    always_comb
    begin
        in_stall = (state_reg == ST_UPDATE) || (out_valid_reg && out_stall);
        accept   = in_valid && !in_stall;
        update   = (state_reg == ST_UPDATE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (update)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            decode_reg <= (func == FUNC_DECODE);
        end
        if (update)
        begin
            data_out_reg <= found ? (decode_reg ? hit_sym : pos) : '0;
        end
    end

    always_comb
    begin
        ctrl.load   = accept;
        ctrl.start  = accept && start_of_block;
        ctrl.decode = (func == FUNC_DECODE);
        ctrl.data   = data_in;
        ctrl.update = update;
        ctrl.found  = found;
        ctrl.pos    = pos;
        ctrl.front  = hit_sym;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        sym_t prev_sym;
        if (i == 0)
        begin : g_front
            assign prev_sym = ctrl.front;
        end
        else
        begin : g_chain
            assign prev_sym = syms[i-1];
        end

        mtf_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .prev_sym (prev_sym),
            .sym      (syms[i]),
            .match    (match[i])
        );
    end

    mtf_reduce #(
        .N (N)
    ) u_reduce (
        .match (match),
        .syms  (syms),
        .found (found),
        .pos   (pos),
        .sym   (hit_sym)
    );

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

endmodule

[rtl/mtf_cell.sv]
// ----------------------------------------------------------------------------
// Move-to-front list cell
// Holds one list entry, compares it against the incoming byte and takes the
// entry of its upper neighbor when the list moves a symbol to the front.
// ----------------------------------------------------------------------------
module mtf_cell #(
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mtf_pkg::cell_ctrl_t ctrl,
    input  mtf_pkg::sym_t     prev_sym,
    output mtf_pkg::sym_t     sym,
    output logic              match
);
    import mtf_pkg::*;

    localparam sym_t MY_INDEX = sym_t'(INDEX);

    sym_t sym_reg;
    sym_t sym_next;
    logic match_reg;
    sym_t eff_sym;

    assign eff_sym = ctrl.start ? MY_INDEX : sym_reg;

    always_comb
    begin
        sym_next = sym_reg;
        if (ctrl.load && ctrl.start)
        begin
            sym_next = MY_INDEX;
        end
        else if (ctrl.update && ctrl.found && (MY_INDEX <= ctrl.pos))
        begin
            sym_next = prev_sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg <= MY_INDEX;
        end
        else
        begin
            sym_reg <= sym_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            match_reg <= ctrl.decode ? (MY_INDEX == ctrl.data) : (eff_sym == ctrl.data);
        end
    end

    assign sym   = sym_reg;
    assign match = match_reg;

endmodule

[rtl/mtf_reduce.sv]
// ----------------------------------------------------------------------------
// Move-to-front match reduction
// Turns the one-hot match vector of the list cells into the hit flag, the
// position of the hit and the symbol stored there.
// ----------------------------------------------------------------------------
module mtf_reduce #(
    parameter int N = 256
) (
    input  logic [N-1:0]                     match,
    input  logic [N-1:0][mtf_pkg::SYM_W-1:0] syms,
    output logic                             found,
    output mtf_pkg::sym_t                    pos,
    output mtf_pkg::sym_t                    sym
);
    import mtf_pkg::*;

    always_comb
    begin
        pos = '0;
        sym = '0;
        for (int i = 0; i < N; i++)
        begin
            pos = pos | ({SYM_W{match[i]}} & sym_t'(i));
            sym = sym | ({SYM_W{match[i]}} & syms[i]);
        end
    end

    assign found = |match;

endmodule
